### sv/scbt_pkg.sv
// Shared types and constants for the strike count blocklist table.
`default_nettype none
package scbt_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int KEY_W = 22;
	localparam int CNT_W = 8;

	localparam logic [CNT_W-1:0] COUNT_MAX = 8'hFF;
	localparam logic [CNT_W-1:0] THRESH_RESET = 8'd3;
	localparam logic [CNT_W-1:0] COUNT_ONE = 8'd1;

	localparam logic [1:0] MODE_QUERY = 2'd0;
	localparam logic [1:0] MODE_FAIL = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;
	localparam logic [1:0] MODE_RESET_CNT = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic [KEY_W-1:0] proc_id;
		logic signed [31:0] user_id;
	} req_t;

	typedef struct packed {
		logic is_blocked;
		logic none_blocked;
		logic table_full;
	} rsp_t;

	// Token that walks the row of cells: first a search sweep, then an apply sweep.
	typedef struct packed {
		logic vld;
		logic apply;
		logic [1:0] mode;
		logic [KEY_W-1:0] key;
		logic root;
		logic found;
		logic alloc;
		logic hit;
		logic nb;
	} tok_t;

endpackage
`default_nettype wire

### sv/scbt_cell.sv
// One table entry of the row, with the registered token stage in front of its neighbour.
`default_nettype none
module scbt_cell (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [scbt_pkg::CNT_W-1:0]          thresh,
	input  wire scbt_pkg::tok_t                      tok_in,
	output scbt_pkg::tok_t                           tok_out
);

	logic [scbt_pkg::KEY_W-1:0] key_q;
	logic used_q;
	logic counting_q;
	logic [scbt_pkg::CNT_W-1:0] count_q;
	logic blocked_q;
	scbt_pkg::tok_t tok_q;

	logic match;
	logic n_used;
	logic n_counting;
	logic [scbt_pkg::CNT_W-1:0] n_count;
	logic n_blocked;
	logic key_we;
	logic [scbt_pkg::CNT_W-1:0] inc;
	scbt_pkg::tok_t t;

	assign match = used_q && (key_q == tok_in.key);

	always_comb begin
		n_used = used_q;
		n_counting = counting_q;
		n_count = count_q;
		n_blocked = blocked_q;
		key_we = 1'b0;
		t = tok_in;
		inc = counting_q ? count_q : '0;
		if (inc != scbt_pkg::COUNT_MAX) begin
			inc = inc + scbt_pkg::COUNT_ONE;
		end
		if (tok_in.vld && tok_in.apply) begin
			if (match) begin
				case (tok_in.mode)
					scbt_pkg::MODE_QUERY: begin
						t.hit = tok_in.hit | (blocked_q & ~tok_in.root);
					end
					scbt_pkg::MODE_FAIL: begin
						n_count = inc;
						n_counting = 1'b1;
						if (inc > thresh) begin
							n_blocked = 1'b1;
						end
						t.hit = n_blocked;
					end
					scbt_pkg::MODE_REMOVE: begin
						n_used = 1'b0;
						n_counting = 1'b0;
						n_count = '0;
						n_blocked = 1'b0;
					end
					default: begin
						// Reset count: a blocked entry keeps its mark and stays in use.
						n_counting = 1'b0;
						n_count = '0;
						n_used = blocked_q;
					end
				endcase
			end else if (tok_in.mode == scbt_pkg::MODE_FAIL && !tok_in.found &&
					!tok_in.alloc && !used_q) begin
				// The first free entry along the row takes an unknown id.
				key_we = 1'b1;
				n_used = 1'b1;
				n_counting = 1'b1;
				n_count = scbt_pkg::COUNT_ONE;
				n_blocked = scbt_pkg::COUNT_ONE > thresh;
				t.alloc = 1'b1;
				t.hit = n_blocked;
			end
			t.nb = tok_in.nb & ~(n_used & n_blocked);
		end else if (tok_in.vld) begin
			t.found = tok_in.found | match;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			counting_q <= 1'b0;
			count_q <= '0;
			blocked_q <= 1'b0;
			tok_q <= '0;
		end else begin
			used_q <= n_used;
			counting_q <= n_counting;
			count_q <= n_count;
			blocked_q <= n_blocked;
			tok_q <= t;
		end
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_q <= tok_in.key;
		end
	end

	assign tok_out = tok_q;

endmodule
`default_nettype wire

### sv/strike_count_blocklist_table.sv
// Top level of the strike count blocklist table: request intake, cell row and result buffer.
//
// Requests arrive on req (req_valid/req_ready) and each gives one result item on rsp
// (rsp_valid/rsp_ready). An item walks the row of ENTRIES cells twice, one cell per
// cycle: a search sweep that finds whether the id is held, then an apply sweep that
// updates the matching entry, or for a failure of an unknown id allocates the lowest
// free one, and gathers the result. The result goes to the output register when the
// apply sweep ends; a new request is taken only once the item before it has left the
// row, as req_ready only rises in the cycle after the apply sweep has finished.
// A finished result waits in the output register while the next request runs; a second
// result that finishes before the first is taken goes to a skid register, and
// req_ready stays low while that register is full.
// The failure threshold is written through cfg_we/cfg_wdata; the user must do so only while
// the block is idle, which the block itself does not enforce. Reset empties the whole table
// at once, clears the result registers and sets the threshold to three.
`default_nettype none
module strike_count_blocklist_table #(
	parameter int ENTRIES = scbt_pkg::ENTRIES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	output logic                            req_ready,
	input  wire scbt_pkg::req_t             req,
	output logic                            rsp_valid,
	input  wire logic                       rsp_ready,
	output scbt_pkg::rsp_t                  rsp,
	input  wire logic                       cfg_we,
	input  wire logic [scbt_pkg::CNT_W-1:0] cfg_wdata
);

	logic [scbt_pkg::CNT_W-1:0] thresh_q;
	logic busy_q;
	logic out_v_q;
	logic skid_v_q;
	scbt_pkg::rsp_t out_q;
	scbt_pkg::rsp_t skid_q;

	scbt_pkg::tok_t chain [ENTRIES+1];
	scbt_pkg::tok_t tail;
	scbt_pkg::rsp_t fin_data;
	logic [ENTRIES-1:0] tok_vld;
	logic accept;
	logic fin;
	logic take;

	assign req_ready = !busy_q && !skid_v_q;
	assign accept = req_valid && req_ready;
	assign tail = chain[ENTRIES];
	assign fin = tail.vld && tail.apply;
	assign take = out_v_q && rsp_ready;

	always_comb begin
		chain[0] = '0;
		if (tail.vld && !tail.apply) begin
			// Search sweep is done: send the same item round for the apply sweep.
			chain[0] = tail;
			chain[0].apply = 1'b1;
			chain[0].alloc = 1'b0;
			chain[0].hit = 1'b0;
			chain[0].nb = 1'b1;
		end else begin
			chain[0].vld = accept;
			chain[0].mode = req.mode;
			chain[0].key = req.proc_id;
			chain[0].root = (req.user_id == 32'sd0);
		end
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		scbt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.thresh  (thresh_q),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
		assign tok_vld[i] = chain[i+1].vld;
	end

	always_comb begin
		fin_data.is_blocked = tail.hit;
		fin_data.none_blocked = tail.nb;
		fin_data.table_full = (tail.mode == scbt_pkg::MODE_FAIL) && !tail.found &&
			!tail.alloc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= scbt_pkg::THRESH_RESET;
			busy_q <= 1'b0;
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				thresh_q <= cfg_wdata;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fin) begin
				busy_q <= 1'b0;
			end
			if (fin) begin
				if (!out_v_q || take) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (take) begin
				if (skid_v_q) begin
					skid_v_q <= 1'b0;
				end else begin
					out_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			if (!out_v_q || take) begin
				out_q <= fin_data;
			end else begin
				skid_q <= fin_data;
			end
		end else if (take && skid_v_q) begin
			out_q <= skid_q;
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp = out_q;

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld))
		else $error("more than one item in the cell row");

	a_fin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> busy_q)
		else $error("item finished while the block was idle");

	a_fin_skid: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> !skid_v_q)
		else $error("item finished with the skid register still full");

	a_skid_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register full with the output register empty");

	a_busy_ready: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && !req_ready)
		else $error("request taken while an item was in the row");

endmodule
`default_nettype wire

### tb/sv/tb_strike_count_blocklist_table.sv
// Self-checking testbench for the strike count blocklist table, with its own table predictor.
module tb_strike_count_blocklist_table;
	timeunit 1ns;
	timeprecision 1ps;

	import scbt_pkg::*;

	localparam int N_SLOTS = ENTRIES_DEF;
	localparam int DRAIN_CYCLES = 2 * N_SLOTS + 8;
	localparam int IDLE_LIMIT = 3000;
	localparam int PRESSURE_AT = 450;
	localparam int PRESSURE_LEN = 400;
	localparam int N_DIRECTED = 20;

	typedef struct {
		logic [1:0] mode;
		logic [KEY_W-1:0] id;
		logic [31:0] user;
		bit typed;
		rsp_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	logic cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	// Predicted table contents and threshold.
	logic [KEY_W-1:0] tbl_key [N_SLOTS];
	bit tbl_used [N_SLOTS];
	bit tbl_counting [N_SLOTS];
	bit tbl_blocked [N_SLOTS];
	logic [CNT_W-1:0] tbl_count [N_SLOTS];
	logic [CNT_W-1:0] threshold;

	rsp_t pending_verdicts [$];
	logic [KEY_W-1:0] id_pool [$];
	dir_row_t dir_rows [N_DIRECTED];

	int err_count = 0;
	int items_sent = 0;
	int results_seen = 0;
	int blocked_answers = 0;
	int full_refusals = 0;
	int settings_used = 1;
	bit steady = 1'b0;

	strike_count_blocklist_table #(
		.ENTRIES(N_SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_entry(int s);
		tbl_used[s] = 1'b0;
		tbl_counting[s] = 1'b0;
		tbl_count[s] = '0;
		tbl_blocked[s] = 1'b0;
	endfunction

	// Applies one request to the predicted table and returns the result it should give.
	function automatic rsp_t strike_predict(req_t r);
		int hit;
		int spare;
		logic [CNT_W-1:0] c;
		rsp_t o;
		hit = -1;
		spare = -1;
		o = '0;
		for (int i = 0; i < N_SLOTS; i++) begin
			if (hit < 0 && tbl_used[i] && tbl_key[i] == r.proc_id) hit = i;
			if (spare < 0 && !tbl_used[i]) spare = i;
		end
		case (r.mode)
			MODE_QUERY: begin
				o.is_blocked = (r.user_id != 0) && (hit >= 0) && tbl_blocked[hit];
			end
			MODE_FAIL: begin
				if (hit < 0 && spare >= 0) begin
					hit = spare;
					clear_entry(hit);
					tbl_key[hit] = r.proc_id;
					tbl_used[hit] = 1'b1;
				end
				if (hit < 0) begin
					o.table_full = 1'b1;
				end else begin
					c = tbl_counting[hit] ? tbl_count[hit] : '0;
					if (c != COUNT_MAX) c = c + COUNT_ONE;
					tbl_count[hit] = c;
					tbl_counting[hit] = 1'b1;
					if (c > threshold) tbl_blocked[hit] = 1'b1;
					o.is_blocked = tbl_blocked[hit];
				end
			end
			MODE_REMOVE: begin
				if (hit >= 0) clear_entry(hit);
			end
			default: begin
				if (hit >= 0) begin
					tbl_counting[hit] = 1'b0;
					tbl_count[hit] = '0;
					if (!tbl_blocked[hit]) tbl_used[hit] = 1'b0;
				end
			end
		endcase
		o.none_blocked = 1'b1;
		for (int i = 0; i < N_SLOTS; i++) begin
			if (tbl_used[i] && tbl_blocked[i]) o.none_blocked = 1'b0;
		end
		return o;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("ERROR %0t ns result %0d %s: got %0d, expected %0d",
			$time, results_seen, what, got, want);
		err_count++;
	endtask

	// Offers one item; the expectation is queued at the edge where it is accepted.
	task automatic send_item(input req_t it, input bit typed, input rsp_t want);
		int gap;
		rsp_t pred;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		do @(posedge clk); while (!req_ready);
		pred = strike_predict(it);
		pending_verdicts.push_back(typed ? want : pred);
		items_sent++;
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [CNT_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		threshold = value;
		settings_used++;
	endtask

	function automatic req_t make_item(int wq, int wf, int wr);
		req_t it;
		int r;
		r = $urandom_range(0, 99);
		if (r < wq) it.mode = MODE_QUERY;
		else if (r < wq + wf) it.mode = MODE_FAIL;
		else if (r < wq + wf + wr) it.mode = MODE_REMOVE;
		else it.mode = MODE_RESET_CNT;
		// Mostly ids from the working set, now and then a stray one.
		if ($urandom_range(0, 99) < 5) it.proc_id = KEY_W'($urandom);
		else it.proc_id = id_pool[$urandom_range(0, id_pool.size() - 1)];
		it.user_id = ($urandom_range(0, 99) < 20) ? 32'sd0 : $signed($urandom);
		return it;
	endfunction

	task automatic run_phase(input logic [CNT_W-1:0] thr, input int n, input int pool_n,
			input int wq, input int wf, input int wr, input bit calm);
		wait_idle();
		write_threshold(thr);
		steady = calm;
		if (pool_n > 0) begin
			id_pool.delete();
			repeat (pool_n) id_pool.push_back(KEY_W'($urandom));
		end
		repeat (n) send_item(make_item(wq, wf, wr), 1'b0, '0);
	endtask

	// Result side: checks, random stalls and one long hold-off.
	initial begin
		int hold_left;
		bit pressure_done;
		rsp_t want;
		hold_left = 0;
		pressure_done = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				if (pending_verdicts.size() == 0) begin
					report_mismatch("unexpected item", int'(rsp), -1);
				end else begin
					want = pending_verdicts.pop_front();
					if (rsp.is_blocked !== want.is_blocked)
						report_mismatch("is_blocked", rsp.is_blocked, want.is_blocked);
					if (rsp.none_blocked !== want.none_blocked)
						report_mismatch("none_blocked", rsp.none_blocked, want.none_blocked);
					if (rsp.table_full !== want.table_full)
						report_mismatch("table_full", rsp.table_full, want.table_full);
				end
				if (rsp.is_blocked === 1'b1) blocked_answers++;
				if (rsp.table_full === 1'b1) full_refusals++;
				results_seen++;
			end
			if (!pressure_done && results_seen >= PRESSURE_AT) begin
				pressure_done = 1'b1;
				hold_left = PRESSURE_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (!steady && $urandom_range(0, 99) < 15) begin
				hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
					: $urandom_range(1, 3);
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Ends the run if neither channel moves an item for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		req_t it;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		for (int i = 0; i < N_SLOTS; i++) begin
			tbl_key[i] = '0;
			clear_entry(i);
		end
		threshold = THRESH_RESET;

		// Threshold three after reset: walk one id up to blocked, then clear it again.
		dir_rows = '{
			'{MODE_QUERY, 22'h3FFFFF, 32'h0000_0001, 1'b1, '{1'b0, 1'b1, 1'b0}},
			'{MODE_FAIL, 22'h3FFFFF, 32'h0000_0001, 1'b1, '{1'b0, 1'b1, 1'b0}},
			'{MODE_FAIL, 22'h3FFFFF, 32'h0000_0001, 1'b0, '{1'b0, 1'b0, 1'b0}},
			'{MODE_FAIL, 22'h3FFFFF, 32'h0000_0001, 1'b0, '{1'b0, 1'b0, 1'b0}},
			'{MODE_FAIL, 22'h3FFFFF, 32'h0000_0001, 1'b1, '{1'b1, 1'b0, 1'b0}},
			'{MODE_QUERY, 22'h3FFFFF, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 1'b0}},
			'{MODE_QUERY, 22'h3FFFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 1'b0}},
			'{MODE_QUERY, 22'h3FFFFF, 32'h8000_0000, 1'b1, '{1'b1, 1'b0, 1'b0}},
			'{MODE_RESET_CNT, 22'h3FFFFF, 32'h0000_0001, 1'b1, '{1'b0, 1'b0, 1'b0}},
			'{MODE_QUERY, 22'h3FFFFF, 32'h7FFF_FFFF, 1'b1, '{1'b1, 1'b0, 1'b0}},
			'{MODE_FAIL, 22'h3FFFFF, 32'h0000_0001, 1'b1, '{1'b1, 1'b0, 1'b0}},
			'{MODE_FAIL, 22'h000000, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 1'b0}},
			'{MODE_RESET_CNT, 22'h000000, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 1'b0}},
			'{MODE_QUERY, 22'h000000, 32'h0000_0001, 1'b1, '{1'b0, 1'b0, 1'b0}},
			'{MODE_REMOVE, 22'h3FFFFF, 32'h0000_0001, 1'b1, '{1'b0, 1'b1, 1'b0}},
			'{MODE_QUERY, 22'h3FFFFF, 32'h0000_0001, 1'b1, '{1'b0, 1'b1, 1'b0}},
			'{MODE_REMOVE, 22'h155555, 32'h0000_0001, 1'b1, '{1'b0, 1'b1, 1'b0}},
			'{MODE_RESET_CNT, 22'h2AAAAA, 32'h0000_0001, 1'b1, '{1'b0, 1'b1, 1'b0}},
			'{MODE_FAIL, 22'h2AAAAA, 32'h0000_0001, 1'b0, '{1'b0, 1'b0, 1'b0}},
			'{MODE_REMOVE, 22'h2AAAAA, 32'h0000_0001, 1'b0, '{1'b0, 1'b0, 1'b0}}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			it.mode = dir_rows[i].mode;
			it.proc_id = dir_rows[i].id;
			it.user_id = $signed(dir_rows[i].user);
			send_item(it, dir_rows[i].typed, dir_rows[i].want);
		end

		run_phase(8'd0, 80, 6, 30, 40, 15, 1'b0);
		// One id hammered with the highest register value: it saturates and is never blocked.
		run_phase(8'd255, 290, 1, 0, 100, 0, 1'b1);
		// Same id, same saturated count: the next failure now blocks it.
		run_phase(8'd254, 30, 0, 20, 80, 0, 1'b0);
		// More ids than entries, mostly failures, so the table runs full.
		run_phase(8'd7, 110, 24, 20, 65, 5, 1'b0);
		run_phase(CNT_W'($urandom_range(1, 253)), 70, 12, 30, 40, 15, 1'b0);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_verdicts.size() != 0) err_count++;

		$display("Covered %0d requests over %0d thresholds, with saturation and a full table.",
			items_sent, settings_used);
		$display("Checked %0d results: %0d blocked answers, %0d full-table refusals, %0d errors.",
			results_seen, blocked_answers, full_refusals, err_count);
		if (err_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
